FILE: hdl/max_height_pyramid_defines.svh
// assertion macros shared by the max height pyramid checker
// no dependencies; included by the checker file
`ifndef MAX_HEIGHT_PYRAMID_DEFINES_SVH
`define MAX_HEIGHT_PYRAMID_DEFINES_SVH

// clocked assertion, disabled while reset is asserted
`define MHP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define MHP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/mhp_pkg.sv
// shared types and constants of the max height pyramid
// no dependencies; used by the interfaces, the top level and the checker
`default_nettype none

package mhp_pkg;

	// default sizes
	localparam int MAX_SQUARES_DEF = 1024;
	localparam int MAX_LEVELS_DEF  = 10;

	// field widths
	localparam int CFG_W    = 11;
	localparam int HEIGHT_W = 16;
	localparam int LEVEL_W  = 4;
	localparam int CELL_W   = 12;
	localparam int ACTION_W = 2;
	localparam int CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SQUARES_X = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SQUARES_Z = 1'd1;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

	typedef struct packed {
		logic [ACTION_W-1:0]      action;
		logic [HEIGHT_W-1:0]      height_sample;
		logic [LEVEL_W-1:0]       query_level;
		logic signed [CELL_W-1:0] query_cell_x;
		logic signed [CELL_W-1:0] query_cell_z;
	} in_word_t;

	typedef struct packed {
		logic [HEIGHT_W-1:0] max_height;
		logic                pyramid_ready;
		logic                level_valid;
	} out_word_t;

endpackage

`default_nettype wire

FILE: hdl/mhp_req_if.sv
// request channel: valid, ready and one input word
// depends on mhp_pkg
`default_nettype none

interface mhp_req_if;
	logic              valid;
	logic              ready;
	mhp_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/mhp_rsp_if.sv
// response channel: valid, ready and one result word
// depends on mhp_pkg
`default_nettype none

interface mhp_rsp_if;
	logic               valid;
	logic               ready;
	mhp_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/mhp_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module mhp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: hdl/max_height_pyramid.sv
// max height pyramid: corner store, pyramid build sequencer and query path
// depends on mhp_pkg, mhp_req_if, mhp_rsp_if and mhp_ram
//
//  channel | dir | word                                              | handshake
//  req     | in  | action, height_sample, query_level, cell x and z  | valid/ready
//  rsp     | out | max_height, pyramid_ready, level_valid            | valid/ready
//  cfg     | in  | cfg_idx, cfg_wdata                                | cfg_we, no stall
//
// a load or a clear is done in idle; a query steps through address multiply,
// ram read and data return, where it may wait on rsp.
// the last load starts the build: per level a setup step, then per cell the
// tap reads (9 on level 1, 4 above) and a drain until the max is written.
// no word is taken during the build or in the cycle after a cfg write.
// reset clears control and configuration only; memory data is used only after it is written.
`default_nettype none

module max_height_pyramid #(
	parameter int MAX_SQUARES = mhp_pkg::MAX_SQUARES_DEF,
	parameter int MAX_LEVELS  = mhp_pkg::MAX_LEVELS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	mhp_req_if.sink                           req,
	mhp_rsp_if.source                         rsp,
	input  wire logic                         cfg_we,
	input  wire logic [mhp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [mhp_pkg::CFG_W-1:0]    cfg_wdata
);

	localparam int SQW  = $clog2(MAX_SQUARES + 1);
	localparam int PW   = SQW + 1;
	localparam int EW   = (SQW > mhp_pkg::CFG_W) ? SQW : mhp_pkg::CFG_W;
	localparam int CD   = (MAX_SQUARES + 1) * (MAX_SQUARES + 1);
	localparam int LD   = 2 * (MAX_SQUARES / 2 + 1) * (MAX_SQUARES / 2 + 1);
	localparam int CAW  = $clog2(CD);
	localparam int LAW  = $clog2(LD);
	localparam int AW   = (CAW > LAW) ? CAW : LAW;
	localparam int CNTW = $clog2(CD + 1);
	localparam int LVW  = $clog2(MAX_LEVELS + 1);
	localparam int QW   = (mhp_pkg::CELL_W > PW) ? mhp_pkg::CELL_W : PW;
	localparam int HW   = mhp_pkg::HEIGHT_W;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_BLEVEL = 7'b0000010,
		ST_BISSUE = 7'b0000100,
		ST_BDRAIN = 7'b0001000,
		ST_QADDR  = 7'b0010000,
		ST_QREAD  = 7'b0100000,
		ST_QDATA  = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration and derived geometry
	logic [mhp_pkg::CFG_W-1:0] sx_q, sz_q;
	logic                      cfg_hold_q;
	logic [SQW-1:0]            ex_q, ez_q;
	logic                      empty_q;
	logic [CNTW-1:0]           total_q;
	logic [LVW-1:0]            top_q;

	logic [EW-1:0]  sx_ext, sz_ext;
	logic [SQW-1:0] ex_c, ez_c, m_c, v_c;
	logic [4:0]     bw_c;
	logic [LVW-1:0] top_c;

	// load state
	logic [CNTW-1:0] loaded_q;
	logic            built_q;

	// build sequencer
	logic [LVW-1:0] lvl_q;
	logic [SQW-1:0] cur_cx_q, cur_cz_q, prev_cx_q, prev_cz_q;
	logic [LAW-1:0] off_acc_q, prev_off_q, wa_q;
	logic [SQW-1:0] i_q, j_q;
	logic [1:0]     a_q, b_q;
	logic           lvl1_q;
	logic [LAW-1:0] g_base_q;
	logic [SQW-1:0] g_row_q, g_xlim_q, g_zlim_q;

	logic [SQW-1:0] tab_cx [MAX_LEVELS + 1];
	logic [SQW-1:0] tab_cz [MAX_LEVELS + 1];
	logic [LAW-1:0] tab_off [MAX_LEVELS + 1];

	// tap read pipeline
	logic           v_s1, first_s1, last_s1, src_s1;
	logic [AW-1:0]  addr_s1;
	logic           v_s2, first_s2, last_s2, src_s2;
	logic [HW-1:0]  acc_q;

	// query
	logic [mhp_pkg::LEVEL_W-1:0]     q_lvl_q;
	logic signed [mhp_pkg::CELL_W-1:0] q_x_q, q_z_q;
	logic [LAW-1:0]                  q_addr_q;
	logic                            q_lv_q, q_hv_q;

	// output register
	logic               out_v_q;
	mhp_pkg::out_word_t out_q;

	// ram ports
	logic           c_we, l_we;
	logic [HW-1:0]  c_rdata, l_rdata, l_wdata;
	logic [LAW-1:0] l_raddr;

	// effective squares and top level
	always_comb begin
		sx_ext = EW'(sx_q);
		sz_ext = EW'(sz_q);
		ex_c = (sx_ext > EW'(MAX_SQUARES)) ? SQW'(MAX_SQUARES) : sx_ext[SQW-1:0];
		ez_c = (sz_ext > EW'(MAX_SQUARES)) ? SQW'(MAX_SQUARES) : sz_ext[SQW-1:0];
		m_c  = (ex_c < ez_c) ? ex_c : ez_c;
		v_c  = m_c - SQW'(2);
		bw_c = 5'd1;
		if (m_c > SQW'(2)) begin
			bw_c = 5'd0;
			for (int k = 0; k < SQW; k++) begin
				if (v_c[k]) begin
					bw_c = 5'(k + 1);
				end
			end
		end
		top_c = (bw_c > 5'(MAX_LEVELS)) ? LVW'(MAX_LEVELS) : bw_c[LVW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q       <= '0;
			sz_q       <= '0;
			cfg_hold_q <= 1'b0;
			ex_q       <= '0;
			ez_q       <= '0;
			empty_q    <= 1'b1;
			total_q    <= '0;
			top_q      <= '0;
		end else begin
			cfg_hold_q <= cfg_we;
			if (cfg_we && cfg_idx == mhp_pkg::CFG_SQUARES_X) begin
				sx_q <= cfg_wdata;
			end
			if (cfg_we && cfg_idx == mhp_pkg::CFG_SQUARES_Z) begin
				sz_q <= cfg_wdata;
			end
			ex_q    <= ex_c;
			ez_q    <= ez_c;
			empty_q <= (ex_c == '0) || (ez_c == '0);
			total_q <= CNTW'((2*SQW+2)'(ex_c + SQW'(1)) * (2*SQW+2)'(ez_c + SQW'(1)));
			top_q   <= top_c;
		end
	end

	// input acceptance
	logic acc_in, do_load, do_query, do_clear;
	assign req.ready = (state_q == ST_IDLE) && !cfg_hold_q;
	assign acc_in    = req.valid && req.ready;
	assign do_load   = acc_in && req.data.action == mhp_pkg::ACT_LOAD && !empty_q
		&& !built_q && loaded_q < total_q;
	assign do_query  = acc_in && req.data.action == mhp_pkg::ACT_QUERY;
	assign do_clear  = acc_in && req.data.action == mhp_pkg::ACT_CLEAR;

	// tap address generation
	logic [1:0]      n_max;
	logic [PW-1:0]   xpos, zpos;
	logic [SQW-1:0]  xc, zc;
	logic [2*SQW-1:0] tprod;
	logic [AW-1:0]   taddr;
	logic            tfirst, tlast;

	always_comb begin
		n_max  = lvl1_q ? 2'd2 : 2'd1;
		xpos   = PW'({i_q, 1'b0}) + PW'(a_q);
		zpos   = PW'({j_q, 1'b0}) + PW'(b_q);
		xc     = (xpos > PW'(g_xlim_q)) ? g_xlim_q : xpos[SQW-1:0];
		zc     = (zpos > PW'(g_zlim_q)) ? g_zlim_q : zpos[SQW-1:0];
		tprod  = zc * g_row_q;
		taddr  = AW'(g_base_q) + AW'(tprod) + AW'(xc);
		tfirst = (a_q == 2'd0) && (b_q == 2'd0);
		tlast  = (a_q == n_max) && (b_q == n_max);
	end

	// level geometry for setup
	logic [SQW-1:0]   nx_cx, nx_cz;
	logic [2*SQW-1:0] lvl_cells;
	assign nx_cx     = (ex_q >> lvl_q) + SQW'(1);
	assign nx_cz     = (ez_q >> lvl_q) + SQW'(1);
	assign lvl_cells = cur_cx_q * cur_cz_q;

	// max accumulate at ram return
	logic [HW-1:0] tdata, acc_nx;
	assign tdata   = src_s2 ? c_rdata : l_rdata;
	assign acc_nx  = (first_s2 || tdata > acc_q) ? tdata : acc_q;
	assign l_we    = v_s2 && last_s2;
	assign l_wdata = acc_nx;

	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_q <= acc_nx;
		end
	end

	// query address
	logic                    q_lv_c;
	logic [LVW-1:0]          q_tidx;
	logic [SQW-1:0]          q_cxm1, q_czm1, q_xc, q_zc;
	logic [QW-1:0]           q_xe, q_ze;
	logic [2*SQW-1:0]        q_prod;

	always_comb begin
		q_lv_c = !empty_q && q_lvl_q != '0 && 5'(q_lvl_q) <= 5'(top_q);
		q_tidx = q_lv_c ? q_lvl_q[LVW-1:0] : '0;
		q_cxm1 = tab_cx[q_tidx] - SQW'(1);
		q_czm1 = tab_cz[q_tidx] - SQW'(1);
		q_xe   = QW'(q_x_q[mhp_pkg::CELL_W-2:0]);
		q_ze   = QW'(q_z_q[mhp_pkg::CELL_W-2:0]);
		if (q_x_q[mhp_pkg::CELL_W-1]) begin
			q_xc = '0;
		end else if (q_xe > QW'(q_cxm1)) begin
			q_xc = q_cxm1;
		end else begin
			q_xc = q_xe[SQW-1:0];
		end
		if (q_z_q[mhp_pkg::CELL_W-1]) begin
			q_zc = '0;
		end else if (q_ze > QW'(q_czm1)) begin
			q_zc = q_czm1;
		end else begin
			q_zc = q_ze[SQW-1:0];
		end
		q_prod = q_zc * tab_cx[q_tidx];
	end

	// memories
	assign c_we    = do_load;
	assign l_raddr = (state_q == ST_QREAD || state_q == ST_QDATA) ? q_addr_q : addr_s1[LAW-1:0];

	mhp_ram #(.WIDTH(HW), .DEPTH(CD)) u_corner_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (loaded_q[CAW-1:0]),
		.wdata (req.data.height_sample),
		.raddr (addr_s1[CAW-1:0]),
		.rdata (c_rdata)
	);

	mhp_ram #(.WIDTH(HW), .DEPTH(LD)) u_level_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (wa_q),
		.wdata (l_wdata),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	// level table, written at level setup
	always_ff @(posedge clk) begin
		if (state_q == ST_BLEVEL) begin
			tab_cx[lvl_q]  <= nx_cx;
			tab_cz[lvl_q]  <= nx_cz;
			tab_off[lvl_q] <= off_acc_q;
		end
	end

	// tap pipeline payload
	always_ff @(posedge clk) begin
		addr_s1  <= taddr;
		first_s1 <= tfirst;
		last_s1  <= tlast;
		src_s1   <= lvl1_q;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		src_s2   <= src_s1;
	end

	// query payload
	always_ff @(posedge clk) begin
		if (do_query) begin
			q_lvl_q <= req.data.query_level;
			q_x_q   <= req.data.query_cell_x;
			q_z_q   <= req.data.query_cell_z;
		end
		if (state_q == ST_QADDR) begin
			q_addr_q <= LAW'(tab_off[q_tidx]) + LAW'(q_prod) + LAW'(q_xc);
			q_lv_q   <= q_lv_c;
			q_hv_q   <= q_lv_c && built_q;
		end
	end

	// build geometry payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_BLEVEL: begin
				cur_cx_q <= nx_cx;
				cur_cz_q <= nx_cz;
				wa_q     <= off_acc_q;
				lvl1_q   <= (lvl_q == LVW'(1));
				if (lvl_q == LVW'(1)) begin
					g_base_q <= '0;
					g_row_q  <= ex_q + SQW'(1);
					g_xlim_q <= ex_q;
					g_zlim_q <= ez_q;
				end else begin
					g_base_q <= prev_off_q;
					g_row_q  <= prev_cx_q;
					g_xlim_q <= prev_cx_q - SQW'(1);
					g_zlim_q <= prev_cz_q - SQW'(1);
				end
			end
			ST_BDRAIN: begin
				if (last_s2 && v_s2) begin
					wa_q <= wa_q + LAW'(1);
					if (i_q == cur_cx_q - SQW'(1) && j_q == cur_cz_q - SQW'(1)) begin
						prev_cx_q  <= cur_cx_q;
						prev_cz_q  <= cur_cz_q;
						prev_off_q <= off_acc_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			loaded_q  <= '0;
			built_q   <= 1'b0;
			lvl_q     <= '0;
			off_acc_q <= '0;
			i_q       <= '0;
			j_q       <= '0;
			a_q       <= '0;
			b_q       <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_v_q   <= 1'b0;
			out_q     <= '0;
		end else begin
			v_s1 <= (state_q == ST_BISSUE);
			v_s2 <= v_s1;
			if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			if (cfg_we) begin
				loaded_q <= '0;
				built_q  <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (do_clear) begin
						loaded_q <= '0;
						built_q  <= 1'b0;
					end
					if (do_load) begin
						loaded_q <= loaded_q + CNTW'(1);
						if (loaded_q + CNTW'(1) == total_q) begin
							state_q   <= ST_BLEVEL;
							lvl_q     <= LVW'(1);
							off_acc_q <= '0;
						end
					end
					if (do_query) begin
						state_q <= ST_QADDR;
					end
				end
				ST_BLEVEL: begin
					i_q     <= '0;
					j_q     <= '0;
					a_q     <= '0;
					b_q     <= '0;
					state_q <= ST_BISSUE;
				end
				ST_BISSUE: begin
					if (a_q == n_max) begin
						a_q <= '0;
						b_q <= b_q + 2'd1;
					end else begin
						a_q <= a_q + 2'd1;
					end
					if (tlast) begin
						state_q <= ST_BDRAIN;
					end
				end
				ST_BDRAIN: begin
					if (v_s2 && last_s2) begin
						a_q     <= '0;
						b_q     <= '0;
						state_q <= ST_BISSUE;
						if (i_q == cur_cx_q - SQW'(1)) begin
							i_q <= '0;
							if (j_q == cur_cz_q - SQW'(1)) begin
								off_acc_q <= off_acc_q + LAW'(lvl_cells);
								if (lvl_q == top_q) begin
									built_q <= 1'b1;
									state_q <= ST_IDLE;
								end else begin
									lvl_q   <= lvl_q + LVW'(1);
									state_q <= ST_BLEVEL;
								end
							end else begin
								j_q <= j_q + SQW'(1);
							end
						end else begin
							i_q <= i_q + SQW'(1);
						end
					end
				end
				ST_QADDR: begin
					state_q <= ST_QREAD;
				end
				ST_QREAD: begin
					state_q <= ST_QDATA;
				end
				ST_QDATA: begin
					if (!out_v_q || rsp.ready) begin
						out_v_q             <= 1'b1;
						out_q.max_height    <= q_hv_q ? l_rdata : '0;
						out_q.pyramid_ready <= built_q;
						out_q.level_valid   <= q_lv_q;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

endmodule

`default_nettype wire

FILE: hdl/mhp_checker.sv
// port level checks of the max height pyramid, bound to the top level
// depends on max_height_pyramid_defines.svh and mhp_pkg
`default_nettype none
`include "max_height_pyramid_defines.svh"

module mhp_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        req_ready,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_ready,
	input wire logic [mhp_pkg::HEIGHT_W-1:0] rsp_max_height,
	input wire logic                        rsp_pyramid_ready,
	input wire logic                        rsp_level_valid,
	input wire logic                        cfg_we
);

	// a waiting word stays until taken
	`MHP_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp word dropped")
	// a nonzero height needs a valid level on a built pyramid
	`MHP_ASSERT(a_height_ok, rsp_valid && rsp_max_height != '0 |-> rsp_level_valid && rsp_pyramid_ready, "height on invalid query")
	// a register write blocks the next word in the following cycle
	`MHP_ASSERT(a_cfg_gap, cfg_we |=> !req_ready, "word taken right after cfg write")
	// nothing is offered while in reset
	`MHP_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !rsp_valid, "rsp valid in reset")

endmodule

bind max_height_pyramid mhp_checker u_mhp_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_max_height    (rsp.data.max_height),
	.rsp_pyramid_ready (rsp.data.pyramid_ready),
	.rsp_level_valid   (rsp.data.level_valid),
	.cfg_we            (cfg_we)
);

`default_nettype wire
